// File: rtl/rsc_pkg.sv
// Types, constants and helper functions shared by the radix string converter.
// Used by rsc_ctrl, rsc_dp and radix_string_converter. No dependencies.
`default_nettype none

package rsc_pkg;

    localparam int CHAR_W    = 8;
    localparam int BASE_W    = 6;
    localparam int FDIG_W    = 4;
    localparam int INT_W     = 31;
    localparam int FRAC_W    = 48;
    localparam int PROD_W    = 54;
    localparam int QDIG_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 5;

    localparam logic [INT_W-1:0]  INT_MAX     = {INT_W{1'b1}};
    localparam logic [FDIG_W-1:0] MAX_FRAC_IN = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAC = 2'd2;

    localparam logic [BASE_W-1:0] IN_BASE_RST  = 6'd10;
    localparam logic [BASE_W-1:0] OUT_BASE_RST = 6'd2;
    localparam logic [FDIG_W-1:0] MAX_FRAC_RST = 4'd7;

    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] DIGITS_DEC = 6'd10;

    localparam logic [STEP_W-1:0] INT_STEPS_M1 = 5'd30;
    localparam logic [STEP_W-1:0] FR_STEPS_M1  = 5'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_INT_INIT,
        ST_INT_DIV,
        ST_INT_STORE,
        ST_INT_RD,
        ST_INT_EMIT,
        ST_PT_EMIT,
        ST_FR_MUL,
        ST_FR_DIV,
        ST_FR_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic acc_update;
        logic int_init;
        logic int_div_step;
        logic int_store;
        logic rd_issue;
        logic emit_int;
        logic emit_point;
        logic fr_mul;
        logic fr_div_step;
        logic emit_frac;
    } dp_cmd_t;

    typedef struct packed {
        logic last_char;
        logic int_more;
        logic int_final;
        logic frac_active;
        logic frac_final;
        logic out_free;
    } dp_stat_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end
        return r;
    endfunction

    function automatic logic [BASE_W-1:0] char_weight(input logic [CHAR_W-1:0] c,
                                                      input logic [BASE_W-1:0] base);
        logic [BASE_W-1:0] w;
        logic              ok;
        w  = '0;
        ok = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            w  = BASE_W'(c - CH_ZERO);
            ok = 1'b1;
        end else if (c >= CH_A && c <= CH_Z) begin
            w  = BASE_W'(c - CH_A) + DIGITS_DEC;
            ok = 1'b1;
        end
        return (ok && (w < base)) ? w : '0;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        logic [BASE_W-1:0] dm;
        logic [CHAR_W-1:0] r;
        dm = (d >= BASE_MAX) ? (d - BASE_MAX) : d;
        if (dm < DIGITS_DEC) begin
            r = CH_ZERO + CHAR_W'(dm);
        end else begin
            r = CH_A + CHAR_W'(dm - DIGITS_DEC);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rsc_ctrl.sv
// Sequencer of the radix string converter: accumulate, integer divide loop,
// digit emission, fraction multiply/divide loop. Depends on rsc_pkg.
`default_nettype none

module rsc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire rsc_pkg::dp_stat_t stat,
    output rsc_pkg::dp_cmd_t      cmd
);

    rsc_pkg::state_t state_reg, state_next;
    logic [rsc_pkg::STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsc_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rsc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = rsc_pkg::ST_ACC;
            end
            rsc_pkg::ST_ACC: begin
                state_next = stat.last_char ? rsc_pkg::ST_INT_INIT : rsc_pkg::ST_IDLE;
            end
            rsc_pkg::ST_INT_INIT: begin
                state_next = rsc_pkg::ST_INT_DIV;
            end
            rsc_pkg::ST_INT_DIV: begin
                if (step_reg == '0) state_next = rsc_pkg::ST_INT_STORE;
            end
            rsc_pkg::ST_INT_STORE: begin
                state_next = stat.int_more ? rsc_pkg::ST_INT_DIV : rsc_pkg::ST_INT_RD;
            end
            rsc_pkg::ST_INT_RD: begin
                state_next = rsc_pkg::ST_INT_EMIT;
            end
            rsc_pkg::ST_INT_EMIT: begin
                if (stat.out_free) begin
                    if (!stat.int_final) begin
                        state_next = rsc_pkg::ST_INT_RD;
                    end else if (stat.frac_active) begin
                        state_next = rsc_pkg::ST_PT_EMIT;
                    end else begin
                        state_next = rsc_pkg::ST_IDLE;
                    end
                end
            end
            rsc_pkg::ST_PT_EMIT: begin
                if (stat.out_free) state_next = rsc_pkg::ST_FR_MUL;
            end
            rsc_pkg::ST_FR_MUL: begin
                state_next = rsc_pkg::ST_FR_DIV;
            end
            rsc_pkg::ST_FR_DIV: begin
                if (step_reg == '0) state_next = rsc_pkg::ST_FR_EMIT;
            end
            rsc_pkg::ST_FR_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.frac_final ? rsc_pkg::ST_IDLE : rsc_pkg::ST_FR_MUL;
                end
            end
            default: state_next = rsc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        unique case (state_reg)
            rsc_pkg::ST_INT_INIT,
            rsc_pkg::ST_INT_STORE: step_next = rsc_pkg::INT_STEPS_M1;
            rsc_pkg::ST_FR_MUL:    step_next = rsc_pkg::FR_STEPS_M1;
            rsc_pkg::ST_INT_DIV,
            rsc_pkg::ST_FR_DIV:    step_next = step_reg - rsc_pkg::STEP_W'(1);
            default:               step_next = step_reg;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            rsc_pkg::ST_IDLE:      cmd.in_ready     = 1'b1;
            rsc_pkg::ST_ACC:       cmd.acc_update   = 1'b1;
            rsc_pkg::ST_INT_INIT:  cmd.int_init     = 1'b1;
            rsc_pkg::ST_INT_DIV:   cmd.int_div_step = 1'b1;
            rsc_pkg::ST_INT_STORE: cmd.int_store    = 1'b1;
            rsc_pkg::ST_INT_RD:    cmd.rd_issue     = 1'b1;
            rsc_pkg::ST_INT_EMIT:  cmd.emit_int     = stat.out_free;
            rsc_pkg::ST_PT_EMIT:   cmd.emit_point   = stat.out_free;
            rsc_pkg::ST_FR_MUL:    cmd.fr_mul       = 1'b1;
            rsc_pkg::ST_FR_DIV:    cmd.fr_div_step  = 1'b1;
            rsc_pkg::ST_FR_EMIT:   cmd.emit_frac    = stat.out_free;
            default:               cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rsc_dp.sv
// Datapath of the radix string converter: number state, bit-serial integer
// divider, digit buffer, fraction multiply/divide and output register.
// Depends on rsc_pkg.
`default_nettype none

module rsc_dp #(
    parameter int INT_BUF_DEPTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rsc_pkg::dp_cmd_t             cmd,
    output rsc_pkg::dp_stat_t                 stat,
    input  wire logic [rsc_pkg::BASE_W-1:0]   in_base,
    input  wire logic [rsc_pkg::BASE_W-1:0]   out_base,
    input  wire logic [rsc_pkg::FDIG_W-1:0]   max_frac,
    input  wire logic                         s_tvalid,
    input  wire logic [rsc_pkg::CHAR_W-1:0]   s_tdata,
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rsc_pkg::CHAR_W-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic [0:0]                        m_tuser
);

    localparam int ADDR_W = (INT_BUF_DEPTH > 1) ? $clog2(INT_BUF_DEPTH) : 1;
    localparam int NDIG_W = $clog2(INT_BUF_DEPTH + 1);
    localparam int ACC_W  = rsc_pkg::INT_W + rsc_pkg::BASE_W + 1;
    localparam int FN_W   = rsc_pkg::FRAC_W + rsc_pkg::BASE_W + 1;
    localparam logic [NDIG_W-1:0] DEPTH_M1 = NDIG_W'(INT_BUF_DEPTH - 1);

    // input latch
    logic [rsc_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       last_reg, last_next;

    // number state
    logic [rsc_pkg::INT_W-1:0]  int_accum_reg, int_accum_next;
    logic [rsc_pkg::FRAC_W-1:0] frac_numer_reg, frac_numer_next;
    logic [rsc_pkg::FRAC_W-1:0] frac_denom_reg, frac_denom_next;
    logic [rsc_pkg::FDIG_W-1:0] frac_count_reg, frac_count_next;
    logic                       point_seen_reg, point_seen_next;
    logic                       saturated_reg, saturated_next;

    // integer conversion
    logic [rsc_pkg::INT_W-1:0]  dq_reg, dq_next;
    logic [rsc_pkg::BASE_W-1:0] rem_reg, rem_next;
    logic [NDIG_W-1:0]          nd_reg, nd_next;
    logic [rsc_pkg::BASE_W-1:0] digit_buf [INT_BUF_DEPTH];
    logic [rsc_pkg::BASE_W-1:0] rd_data_reg;

    // fraction conversion
    logic [rsc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [rsc_pkg::PROD_W-1:0] dsh_reg, dsh_next;
    logic [rsc_pkg::QDIG_W-1:0] q_reg, q_next;
    logic [rsc_pkg::FDIG_W-1:0] fk_reg, fk_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [rsc_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_ovf_reg, out_ovf_next;

    logic                       in_take;
    logic [rsc_pkg::BASE_W-1:0] weight;
    logic [ACC_W-1:0]           acc_full;
    logic [FN_W-1:0]            fn_full;
    logic [FN_W-1:0]            fd_full;
    logic [rsc_pkg::BASE_W:0]   div_t;
    logic                       div_ge;
    logic [NDIG_W-1:0]          nd_m1;
    logic                       emit;
    logic                       emit_last;
    logic                       frac_active;
    logic                       frac_final;
    logic [rsc_pkg::FDIG_W:0]   fk_inc;

    assign in_take = cmd.in_ready && s_tvalid;
    assign weight  = rsc_pkg::char_weight(char_reg, in_base);
    assign acc_full = ACC_W'(int_accum_reg) * ACC_W'(in_base) + ACC_W'(weight);
    assign fn_full  = FN_W'(frac_numer_reg) * FN_W'(in_base) + FN_W'(weight);
    assign fd_full  = FN_W'(frac_denom_reg) * FN_W'(in_base);

    assign div_t  = {rem_reg, dq_reg[rsc_pkg::INT_W-1]};
    assign div_ge = div_t >= {1'b0, out_base};
    assign nd_m1  = nd_reg - NDIG_W'(1);

    assign frac_active = (frac_count_reg != '0) && (frac_numer_reg != '0);
    assign fk_inc      = {1'b0, fk_reg} + (rsc_pkg::FDIG_W + 1)'(1);
    assign frac_final  = (fk_inc == {1'b0, max_frac}) ||
                         (prod_reg[rsc_pkg::FRAC_W-1:0] == '0);

    assign emit = cmd.emit_int || cmd.emit_point || cmd.emit_frac;
    assign emit_last = (cmd.emit_int && (nd_reg == NDIG_W'(1)) && !frac_active) ||
                       (cmd.emit_frac && frac_final);

    assign stat.last_char   = last_reg;
    assign stat.int_more    = (dq_reg != '0) && (nd_reg != DEPTH_M1);
    assign stat.int_final   = (nd_reg == NDIG_W'(1));
    assign stat.frac_active = frac_active;
    assign stat.frac_final  = frac_final;
    assign stat.out_free    = !out_valid_reg || m_tready;

    always_comb begin
        char_next = in_take ? s_tdata : char_reg;
        last_next = in_take ? s_tlast : last_reg;
    end

    always_comb begin
        int_accum_next  = int_accum_reg;
        frac_numer_next = frac_numer_reg;
        frac_denom_next = frac_denom_reg;
        frac_count_next = frac_count_reg;
        point_seen_next = point_seen_reg;
        saturated_next  = saturated_reg;
        if (emit && emit_last) begin
            int_accum_next  = '0;
            frac_numer_next = '0;
            frac_denom_next = rsc_pkg::FRAC_W'(1);
            frac_count_next = '0;
            point_seen_next = 1'b0;
            saturated_next  = 1'b0;
        end else if (cmd.acc_update) begin
            if (char_reg == rsc_pkg::CH_POINT && !point_seen_reg) begin
                point_seen_next = 1'b1;
            end else if (!point_seen_reg) begin
                if (saturated_reg || acc_full > ACC_W'(rsc_pkg::INT_MAX)) begin
                    saturated_next = 1'b1;
                    int_accum_next = rsc_pkg::INT_MAX;
                end else begin
                    int_accum_next = acc_full[rsc_pkg::INT_W-1:0];
                end
            end else if (frac_count_reg < rsc_pkg::MAX_FRAC_IN) begin
                frac_numer_next = fn_full[rsc_pkg::FRAC_W-1:0];
                frac_denom_next = fd_full[rsc_pkg::FRAC_W-1:0];
                frac_count_next = frac_count_reg + rsc_pkg::FDIG_W'(1);
            end
        end
    end

    always_comb begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        nd_next  = nd_reg;
        if (cmd.int_init) begin
            dq_next  = int_accum_reg;
            rem_next = '0;
            nd_next  = '0;
        end else if (cmd.int_div_step) begin
            dq_next  = {dq_reg[rsc_pkg::INT_W-2:0], div_ge};
            rem_next = div_ge ? rsc_pkg::BASE_W'(div_t - {1'b0, out_base})
                              : rsc_pkg::BASE_W'(div_t);
        end else if (cmd.int_store) begin
            rem_next = '0;
            nd_next  = nd_reg + NDIG_W'(1);
        end else if (cmd.emit_int) begin
            nd_next  = nd_m1;
        end
    end

    always_comb begin
        prod_next = prod_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        fk_next   = fk_reg;
        if (cmd.emit_point) begin
            prod_next = rsc_pkg::PROD_W'(frac_numer_reg);
            fk_next   = '0;
        end else if (cmd.fr_mul) begin
            prod_next = rsc_pkg::PROD_W'(prod_reg[rsc_pkg::FRAC_W-1:0]) *
                        rsc_pkg::PROD_W'(out_base);
            dsh_next  = rsc_pkg::PROD_W'(frac_denom_reg) << (rsc_pkg::QDIG_W - 1);
            q_next    = '0;
        end else if (cmd.fr_div_step) begin
            if (prod_reg >= dsh_reg) begin
                prod_next = prod_reg - dsh_reg;
            end
            q_next   = {q_reg[rsc_pkg::QDIG_W-2:0], prod_reg >= dsh_reg};
            dsh_next = dsh_reg >> 1;
        end else if (cmd.emit_frac) begin
            fk_next = fk_inc[rsc_pkg::FDIG_W-1:0];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_last_next  = emit_last;
            out_ovf_next   = saturated_reg;
            if (cmd.emit_point) begin
                out_char_next = rsc_pkg::CH_POINT;
            end else if (cmd.emit_int) begin
                out_char_next = rsc_pkg::digit_char(rd_data_reg);
            end else begin
                out_char_next = rsc_pkg::digit_char(q_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_accum_reg  <= '0;
            frac_numer_reg <= '0;
            frac_denom_reg <= rsc_pkg::FRAC_W'(1);
            frac_count_reg <= '0;
            point_seen_reg <= 1'b0;
            saturated_reg  <= 1'b0;
            nd_reg         <= '0;
            fk_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            int_accum_reg  <= int_accum_next;
            frac_numer_reg <= frac_numer_next;
            frac_denom_reg <= frac_denom_next;
            frac_count_reg <= frac_count_next;
            point_seen_reg <= point_seen_next;
            saturated_reg  <= saturated_next;
            nd_reg         <= nd_next;
            fk_reg         <= fk_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        last_reg     <= last_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.int_store) begin
            digit_buf[nd_reg[ADDR_W-1:0]] <= rem_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= digit_buf[nd_m1[ADDR_W-1:0]];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_char_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

`default_nettype wire

// File: rtl/radix_string_converter.sv
// Top level of the radix string converter: configuration registers,
// sequencer and datapath. Depends on rsc_pkg, rsc_ctrl and rsc_dp.
//
//  Channel  Ports                    Fields (low bit up)
//  in       s_tvalid/s_tready        s_tdata: char_in[7:0]; s_tlast: last_in
//  out      m_tvalid/m_tready        m_tdata: char_out[7:0]; m_tlast: last_out;
//                                    m_tuser: overflow
//  config   cfg_we/cfg_addr/cfg_wdata  0 in_base, 1 out_base, 2 max_frac_digits
//
// A character without tlast is transferred, then multiply-added. On the last one:
// multiply-add and divider setup, then per integer digit a 31-step bit-serial
// divide plus buffer write; each integer digit is read from the buffer and emitted,
// then the point, then per fraction digit a multiply, a 6-step divide and an emit.
// Output stalls hold the sequencer at its emit state; one result waits in the
// output register. Reset clears all control and number state.
`default_nettype none

module radix_string_converter #(
    parameter int INT_BUF_DEPTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [rsc_pkg::BASE_W-1:0]      cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rsc_pkg::CHAR_W-1:0]      s_tdata,   // char_in[7:0]
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rsc_pkg::CHAR_W-1:0]           m_tdata,   // char_out[7:0]
    output logic                                 m_tlast,
    output logic [0:0]                           m_tuser    // overflow
);

    logic [rsc_pkg::BASE_W-1:0] in_base_reg, in_base_next;
    logic [rsc_pkg::BASE_W-1:0] out_base_reg, out_base_next;
    logic [rsc_pkg::FDIG_W-1:0] max_frac_reg, max_frac_next;
    logic [rsc_pkg::FDIG_W-1:0] max_frac_eff;

    rsc_pkg::dp_cmd_t  cmd;
    rsc_pkg::dp_stat_t stat;

    always_comb begin
        in_base_next  = in_base_reg;
        out_base_next = out_base_reg;
        max_frac_next = max_frac_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                rsc_pkg::CFG_IN_BASE:  in_base_next  = cfg_wdata;
                rsc_pkg::CFG_OUT_BASE: out_base_next = cfg_wdata;
                rsc_pkg::CFG_MAX_FRAC: max_frac_next = cfg_wdata[rsc_pkg::FDIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_base_reg  <= rsc_pkg::IN_BASE_RST;
            out_base_reg <= rsc_pkg::OUT_BASE_RST;
            max_frac_reg <= rsc_pkg::MAX_FRAC_RST;
        end else begin
            in_base_reg  <= in_base_next;
            out_base_reg <= out_base_next;
            max_frac_reg <= max_frac_next;
        end
    end

    assign max_frac_eff = (max_frac_reg == '0) ? rsc_pkg::FDIG_W'(1) : max_frac_reg;
    assign s_tready     = cmd.in_ready;

    rsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsc_dp #(
        .INT_BUF_DEPTH (INT_BUF_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_base  (rsc_pkg::clamp_base(in_base_reg)),
        .out_base (rsc_pkg::clamp_base(out_base_reg)),
        .max_frac (max_frac_eff),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
